// ===== sv/bdc_pkg.sv =====
// Shared types and constants for the cubic de Casteljau evaluate/subdivide block.
package bdc_pkg;

  localparam int unsigned CoefW   = 32;
  localparam int unsigned TFrac   = 16;
  localparam int unsigned TW      = TFrac + 1;
  localparam int unsigned ProdW   = CoefW + TW + 1;
  localparam int unsigned D1W     = 35;
  localparam int unsigned D2W     = 37;
  localparam int unsigned IdxW    = 2;
  localparam logic [IdxW-1:0] LastIdx = 2'd3;

  localparam logic [TW-1:0] TOne = TW'(1) << TFrac;

  typedef enum logic {
    OP_EVAL  = 1'b0,
    OP_SPLIT = 1'b1
  } op_e;

  typedef logic signed [CoefW-1:0] coef_t;
  typedef logic [TW-1:0]           tpar_t;

  // after the first cascade level
  typedef struct packed {
    op_e   op;
    coef_t c0;
    coef_t c3;
    coef_t p1_0;
    coef_t p1_1;
    coef_t p1_2;
    tpar_t tw;
    tpar_t tv;
  } s1_t;

  // after the second cascade level
  typedef struct packed {
    op_e                   op;
    coef_t                 c0;
    coef_t                 c3;
    coef_t                 p1_0;
    coef_t                 p1_2;
    coef_t                 p2_0;
    coef_t                 p2_1;
    logic signed [D2W-1:0] d2;
    tpar_t                 tw;
    tpar_t                 tv;
  } s2_t;

  // complete cascade, ready for the result stage
  typedef struct packed {
    op_e                   op;
    coef_t                 c0;
    coef_t                 c3;
    coef_t                 p1_0;
    coef_t                 p1_2;
    coef_t                 p2_0;
    coef_t                 p2_1;
    coef_t                 p3;
    logic signed [D1W-1:0] d1;
    logic signed [D2W-1:0] d2;
  } casc_t;

endpackage

// ===== sv/bdc_if.sv =====
// Valid/ready channel interfaces for the polynomial input and the result output.
interface bdc_in_if;
  logic                valid;
  logic                ready;
  logic                operation;
  bdc_pkg::coef_t      coef_0;
  bdc_pkg::coef_t      coef_1;
  bdc_pkg::coef_t      coef_2;
  bdc_pkg::coef_t      coef_3;
  logic [bdc_pkg::TW-1:0] t;

  modport source (output valid, operation, coef_0, coef_1, coef_2, coef_3, t,
                  input ready);
  modport sink   (input valid, operation, coef_0, coef_1, coef_2, coef_3, t,
                  output ready);
endinterface

interface bdc_out_if;
  logic                            valid;
  logic                            ready;
  logic [bdc_pkg::IdxW-1:0]        index;
  logic                            last;
  logic signed [bdc_pkg::CoefW-1:0] result_a;
  logic signed [bdc_pkg::D1W-1:0]  result_b;
  logic signed [bdc_pkg::D2W-1:0]  result_c;

  modport source (output valid, index, last, result_a, result_b, result_c,
                  input ready);
  modport sink   (input valid, index, last, result_a, result_b, result_c,
                  output ready);
endinterface

// ===== sv/bdc_lerp.sv =====
// One rounded de Casteljau interpolation step: round((a*(1-t) + b*t) / 2^TFrac).
module bdc_lerp (
  input  bdc_pkg::coef_t a_i,
  input  bdc_pkg::coef_t b_i,
  input  bdc_pkg::tpar_t tw_i,
  input  bdc_pkg::tpar_t tv_i,
  output bdc_pkg::coef_t y_o
);

  localparam int unsigned PW = bdc_pkg::ProdW;

  logic signed [PW-1:0] pa;
  logic signed [PW-1:0] pb;
  logic signed [PW-1:0] sum;

  assign pa  = PW'(a_i) * PW'($signed({1'b0, tv_i}));
  assign pb  = PW'(b_i) * PW'($signed({1'b0, tw_i}));
  // half an LSB then floor: ties go toward plus infinity
  assign sum = pa + pb + (PW'(1) <<< (bdc_pkg::TFrac - 1));
  assign y_o = sum[bdc_pkg::TFrac +: bdc_pkg::CoefW];

endmodule

// ===== sv/bdc_cascade.sv =====
// Three-stage pipelined cascade: one interpolation level per register stage.
module bdc_cascade (
  input  logic            clk_i,
  input  logic            rst_ni,
  bdc_in_if.sink          in_i,
  output bdc_pkg::casc_t  res_o,
  output logic            res_valid_o,
  input  logic            res_ready_i
);

  bdc_pkg::s1_t   s1_d, s1_q;
  bdc_pkg::s2_t   s2_d, s2_q;
  bdc_pkg::casc_t s3_d, s3_q;
  logic           v1_q, v2_q, v3_q;
  logic           rdy1, rdy2, rdy3;
  bdc_pkg::tpar_t t_sat;
  logic signed [bdc_pkg::CoefW+1:0] d2_base;
  logic signed [bdc_pkg::CoefW:0]   d1_base;

  assign rdy3       = !v3_q || res_ready_i;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_i.ready = rdy1;

  // clamp t above one to exactly one
  assign t_sat = (in_i.t > bdc_pkg::TOne) ? bdc_pkg::TOne : in_i.t;

  // level one
  assign s1_d.op = bdc_pkg::op_e'(in_i.operation);
  assign s1_d.c0 = in_i.coef_0;
  assign s1_d.c3 = in_i.coef_3;
  assign s1_d.tw = t_sat;
  assign s1_d.tv = bdc_pkg::TOne - t_sat;

  bdc_lerp u_l1_0 (.a_i(in_i.coef_0), .b_i(in_i.coef_1), .tw_i(s1_d.tw), .tv_i(s1_d.tv),
                   .y_o(s1_d.p1_0));
  bdc_lerp u_l1_1 (.a_i(in_i.coef_1), .b_i(in_i.coef_2), .tw_i(s1_d.tw), .tv_i(s1_d.tv),
                   .y_o(s1_d.p1_1));
  bdc_lerp u_l1_2 (.a_i(in_i.coef_2), .b_i(in_i.coef_3), .tw_i(s1_d.tw), .tv_i(s1_d.tv),
                   .y_o(s1_d.p1_2));

  // level two, plus the second difference of level one
  assign d2_base = ($signed((bdc_pkg::CoefW+2)'(s1_q.p1_0))
                  + $signed((bdc_pkg::CoefW+2)'(s1_q.p1_2)))
                  - ($signed((bdc_pkg::CoefW+2)'(s1_q.p1_1)) <<< 1);

  assign s2_d.op   = s1_q.op;
  assign s2_d.c0   = s1_q.c0;
  assign s2_d.c3   = s1_q.c3;
  assign s2_d.p1_0 = s1_q.p1_0;
  assign s2_d.p1_2 = s1_q.p1_2;
  assign s2_d.tw   = s1_q.tw;
  assign s2_d.tv   = s1_q.tv;
  assign s2_d.d2   = ($signed(bdc_pkg::D2W'(d2_base)) <<< 2)
                   + ($signed(bdc_pkg::D2W'(d2_base)) <<< 1);

  bdc_lerp u_l2_0 (.a_i(s1_q.p1_0), .b_i(s1_q.p1_1), .tw_i(s1_q.tw), .tv_i(s1_q.tv),
                   .y_o(s2_d.p2_0));
  bdc_lerp u_l2_1 (.a_i(s1_q.p1_1), .b_i(s1_q.p1_2), .tw_i(s1_q.tw), .tv_i(s1_q.tv),
                   .y_o(s2_d.p2_1));

  // level three, plus the first difference of level two
  assign d1_base = $signed((bdc_pkg::CoefW+1)'(s2_q.p2_1))
                 - $signed((bdc_pkg::CoefW+1)'(s2_q.p2_0));

  assign s3_d.op   = s2_q.op;
  assign s3_d.c0   = s2_q.c0;
  assign s3_d.c3   = s2_q.c3;
  assign s3_d.p1_0 = s2_q.p1_0;
  assign s3_d.p1_2 = s2_q.p1_2;
  assign s3_d.p2_0 = s2_q.p2_0;
  assign s3_d.p2_1 = s2_q.p2_1;
  assign s3_d.d2   = s2_q.d2;
  assign s3_d.d1   = ($signed(bdc_pkg::D1W'(d1_base)) <<< 1)
                   + $signed(bdc_pkg::D1W'(d1_base));

  bdc_lerp u_l3 (.a_i(s2_q.p2_0), .b_i(s2_q.p2_1), .tw_i(s2_q.tw), .tv_i(s2_q.tv),
                 .y_o(s3_d.p3));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_i.valid;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) s1_q <= s1_d;
    if (rdy2) s2_q <= s2_d;
    if (rdy3) s3_q <= s3_d;
  end

  assign res_o       = s3_q;
  assign res_valid_o = v3_q;

endmodule

// ===== sv/bdc_emit.sv =====
// Result stage: holds one finished cascade and sends one or four result beats.
module bdc_emit (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  bdc_pkg::casc_t  res_i,
  input  logic            res_valid_i,
  output logic            res_ready_o,
  bdc_out_if.source       out_o
);

  bdc_pkg::casc_t              hold_q;
  logic                        full_q;
  logic [bdc_pkg::IdxW-1:0]    idx_d, idx_q;
  logic                        last_beat;
  logic                        beat;
  logic                        take;
  logic                        is_split;
  bdc_pkg::coef_t              left_k;
  bdc_pkg::coef_t              right_k;

  assign is_split  = (hold_q.op == bdc_pkg::OP_SPLIT);
  assign last_beat = !is_split || (idx_q == bdc_pkg::LastIdx);
  assign beat      = full_q && out_o.ready;
  assign take      = res_valid_i && (!full_q || (beat && last_beat));
  assign res_ready_o = !full_q || (beat && last_beat);

  assign idx_d = take ? '0 : (beat ? idx_q + bdc_pkg::IdxW'(1) : idx_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      idx_q <= idx_d;
      if (take) full_q <= 1'b1;
      else if (beat && last_beat) full_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) hold_q <= res_i;
  end

  always_comb begin
    case (idx_q)
      2'd0: begin
        left_k  = hold_q.c0;
        right_k = hold_q.p3;
      end
      2'd1: begin
        left_k  = hold_q.p1_0;
        right_k = hold_q.p2_1;
      end
      2'd2: begin
        left_k  = hold_q.p2_0;
        right_k = hold_q.p1_2;
      end
      default: begin
        left_k  = hold_q.p3;
        right_k = hold_q.c3;
      end
    endcase
  end

  assign out_o.valid    = full_q;
  assign out_o.index    = is_split ? idx_q : '0;
  assign out_o.last     = last_beat;
  assign out_o.result_a = is_split ? left_k : hold_q.p3;
  assign out_o.result_b = is_split ? bdc_pkg::D1W'(right_k) : hold_q.d1;
  assign out_o.result_c = is_split ? '0 : hold_q.d2;

endmodule

// ===== sv/bezier_de_casteljau_eval_subdiv_top.sv =====
// Cubic Bernstein polynomial evaluator and splitter, top level.
//
// Each input beat carries four signed Q16.16 control values, a parameter t in
// unsigned Q1.16 (values above one clamp to one) and an operation. The
// de Casteljau cascade runs as a three-stage pipeline, one interpolation
// level per stage, each step rounded to nearest with ties toward plus
// infinity. Evaluate returns one beat: the value at t, the first derivative
// 3*(q1-q0) from level two and the second derivative 6*(q2-2*q1+q0) from
// level one. Subdivide returns four beats, index 0 to 3, each with the left
// piece and right piece control value at that index; result_c is zero and the
// fourth beat carries last. Evaluate items stream at one per cycle and
// subdivide items take four beats each on the single result port, which sends
// one beat per cycle while the output is ready. The input side keeps accepting
// while results wait: the pipeline stages fill behind the result register and
// hold only when all are full.
module bezier_de_casteljau_eval_subdiv_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  bdc_in_if.sink     in_i,
  bdc_out_if.source  out_o
);

  bdc_pkg::casc_t casc;
  logic           casc_valid;
  logic           casc_ready;

  // cascade pipeline: clamp t, three interpolation levels, derivatives
  bdc_cascade u_cascade (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .res_o       (casc),
    .res_valid_o (casc_valid),
    .res_ready_i (casc_ready)
  );

  // result register: hold a finished cascade, advance one beat per handshake
  bdc_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_i       (casc),
    .res_valid_i (casc_valid),
    .res_ready_o (casc_ready),
    .out_o       (out_o)
  );

endmodule
